@@ sv/ifd_pkg.sv @@
// Shared types, constants and the word decode function of the IMU frame decoder.
// Used by every module of the block; depends on nothing else.
package ifd_pkg;

    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int SCALE_W     = 24;
    localparam int TICK_W      = 16;
    localparam int NUM_AXES    = 6;
    localparam int VAL_W       = 15;
    localparam int OUT_W       = 39;
    localparam int PROD_W      = VAL_W + SCALE_W + 1;
    localparam int STORE_DEPTH = 12;
    localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
    localparam int FIRST_END   = 13;
    localparam int SECOND_END  = 22;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  PRE_A         = 8'hEE;
    localparam logic [7:0]  PRE_B         = 8'h50;
    localparam logic [7:0]  SUM_OK        = 8'hFF;
    localparam logic [15:0] WORD_LIMIT    = 16'hB000;
    localparam logic [15:0] WORD_NEG_SET  = 16'hC000;
    localparam logic [15:0] WORD_POS_MASK = 16'h3FFF;

    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 24'd21452;
    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 24'd414662;
    localparam logic [TICK_W-1:0]  TIMEOUT_RST     = 16'd2000;

    localparam logic [1:0] REG_GYRO    = 2'd0;
    localparam logic [1:0] REG_ACCEL   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_CKSUM,
        ST_ZERO,
        ST_TIMEOUT
    } status_t;

    typedef enum logic [1:0] {
        HUNT_EE1,
        HUNT_EE2,
        HUNT_50,
        COLLECT
    } hunt_t;

    // One finished frame or timeout, handed from the front to the back.
    typedef struct packed {
        status_t                             status;
        logic [NUM_AXES-1:0][VAL_W-1:0]      vals;
    } job_t;

    // A raw word above the limit is negative, otherwise its top two bits are dropped.
    // Either way the value fits in 15 signed bits.
    function automatic logic [VAL_W-1:0] decode_word(input logic [7:0] hi,
                                                     input logic [7:0] lo);
        logic [15:0] w;
        logic [15:0] r;
        w = {hi, lo};
        if (w > WORD_LIMIT) begin
            r = w | WORD_NEG_SET;
        end else begin
            r = w & WORD_POS_MASK;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

@@ sv/ifd_front.sv @@
// Front end of the IMU frame decoder: preamble hunt, payload capture, checksums
// and idle timeout. Issues one job per finished frame or timeout. Depends on ifd_pkg.
module ifd_front #(
    parameter int PAYLOAD_LEN = 25
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [7:0]                   s_rx_byte,
    input  logic [ifd_pkg::TICK_W-1:0]   timeout_ticks,
    input  logic                         q_full,
    output logic                         q_push,
    output ifd_pkg::job_t                q_job
);
    import ifd_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_LEN);

    hunt_t              state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         first_reg, first_next;
    logic [7:0]         second_reg, second_next;
    logic [TICK_W-1:0]  idle_reg, idle_next;
    logic [7:0]         store_reg [STORE_DEPTH];
    logic               store_we;
    logic               accept;
    logic               all_zero;
    logic [NUM_AXES-1:0][VAL_W-1:0] dec_vals;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            dec_vals[k] = decode_word(store_reg[2*k], store_reg[2*k+1]);
        end
    end

    assign all_zero = (dec_vals == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= HUNT_EE1;
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            idle_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            idle_reg   <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[count_reg[STORE_IDX_W-1:0]] <= s_rx_byte;
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        idle_next   = idle_reg;
        store_we    = 1'b0;
        q_push      = 1'b0;
        q_job.vals  = dec_vals;
        q_job.status = ST_OK;
        if (accept) begin
            if (s_command) begin
                if (idle_reg >= timeout_ticks) begin
                    idle_next    = '0;
                    count_next   = '0;
                    state_next   = HUNT_EE1;
                    q_push       = 1'b1;
                    q_job.status = ST_TIMEOUT;
                end else begin
                    idle_next = idle_reg + TICK_W'(1);
                end
            end else begin
                idle_next = '0;
                unique case (state_reg)
                    HUNT_EE1: begin
                        if (s_rx_byte == PRE_A) begin
                            state_next = HUNT_EE2;
                        end
                    end
                    HUNT_EE2: begin
                        state_next = (s_rx_byte == PRE_A) ? HUNT_50 : HUNT_EE1;
                    end
                    HUNT_50: begin
                        if (s_rx_byte == PRE_B) begin
                            state_next  = COLLECT;
                            count_next  = '0;
                            first_next  = '0;
                            second_next = '0;
                        end else begin
                            state_next = HUNT_EE1;
                        end
                    end
                    COLLECT: begin
                        store_we = (count_reg < CNT_W'(STORE_DEPTH));
                        if (count_reg < CNT_W'(FIRST_END)) begin
                            first_next = first_reg + s_rx_byte;
                        end else if (count_reg < CNT_W'(SECOND_END)) begin
                            second_next = second_reg + s_rx_byte;
                        end
                        if (count_reg == CNT_W'(PAYLOAD_LEN - 1)) begin
                            // The last word still counts towards the second sum
                            // when the payload is at its shortest.
                            count_next = '0;
                            state_next = HUNT_EE1;
                            q_push     = 1'b1;
                            if (first_next != SUM_OK || second_next != SUM_OK) begin
                                q_job.status = ST_CKSUM;
                            end else if (all_zero) begin
                                q_job.status = ST_ZERO;
                            end else begin
                                q_job.status = ST_OK;
                            end
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                        state_next = HUNT_EE1;
                    end
                endcase
            end
        end
    end

    a_idle_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command && idle_reg < timeout_ticks)
            |=> idle_reg == $past(idle_reg) + TICK_W'(1))
        else $error("idle count did not advance on an idle tick");

    a_frame_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_job.status != ST_TIMEOUT)
            |=> (state_reg == HUNT_EE1 && count_reg == '0))
        else $error("front did not return to hunting after a frame");

    a_word_clears_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_command) |=> idle_reg == '0)
        else $error("received word did not clear the idle count");

endmodule

@@ sv/ifd_queue.sv @@
// Short job queue between the front and back of the IMU frame decoder.
// Register based, first in first out. Depends on ifd_pkg.
module ifd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  ifd_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output ifd_pkg::job_t rd_data
);
    import ifd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/ifd_back.sv @@
// Back end of the IMU frame decoder: scales decoded values, keeps the last
// values and holds the result in an output register. Depends on ifd_pkg.
module ifd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  ifd_pkg::job_t                  q_job,
    output logic                           q_pop,
    input  logic [ifd_pkg::SCALE_W-1:0]    gyro_scale,
    input  logic [ifd_pkg::SCALE_W-1:0]    accel_scale,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_x,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_y,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_z,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_x,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_y,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_z
);
    import ifd_pkg::*;

    logic                      m_valid_reg, m_valid_next;
    status_t                   status_reg;
    logic signed [OUT_W-1:0]   out_reg  [NUM_AXES];
    logic signed [OUT_W-1:0]   last_reg [NUM_AXES];
    logic signed [PROD_W-1:0]  prod     [NUM_AXES];
    logic                      update;

    assign q_pop  = q_valid && (!m_valid_reg || m_ready);
    assign update = q_pop && (q_job.status == ST_OK);

    // Six lanes, one 15 x 25 bit signed multiply each; the scale is zero-extended.
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            prod[k] = $signed(q_job.vals[k])
                    * $signed({1'b0, (k < NUM_AXES / 2) ? gyro_scale : accel_scale});
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) begin
                last_reg[k] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            if (update) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    last_reg[k] <= prod[k][OUT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg <= q_job.status;
            for (int k = 0; k < NUM_AXES; k++) begin
                out_reg[k] <= update ? prod[k][OUT_W-1:0] : last_reg[k];
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = status_reg;
    assign m_gyro_x  = out_reg[0];
    assign m_gyro_y  = out_reg[1];
    assign m_gyro_z  = out_reg[2];
    assign m_accel_x = out_reg[3];
    assign m_accel_y = out_reg[4];
    assign m_accel_z = out_reg[5];

    a_keep_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_job.status != ST_OK)
            |=> (last_reg[0] == $past(last_reg[0]) && last_reg[5] == $past(last_reg[5])))
        else $error("last values changed on a frame that was not accepted");

    a_pop_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid_reg)
        else $error("popped job did not reach the output register");

    a_out_tracks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg[0] == last_reg[0] && out_reg[3] == last_reg[3]))
        else $error("held result differs from the last values");

endmodule

@@ sv/imu_frame_decoder.sv @@
// IMU frame decoder: takes one word per clock (a received serial byte or an idle
// tick) and sustains one word per cycle. A job for a finished frame or timeout
// passes the job queue and the output register to the m_ side; the front stalls only
// when the two-entry job queue and the output register are all full. Frames begin
// with EE EE 50, carry PAYLOAD_LEN bytes, and report ok, checksum failure, an
// all-zero frame (previous values repeated) or an idle timeout, with six signed
// Q15.24 values scaled by the gyro and accel registers. Configure only while idle.
// Top level: APB register file, front end, job queue and back end.
// Depends on ifd_pkg, ifd_front, ifd_queue and ifd_back.
module imu_frame_decoder #(
    parameter int PAYLOAD_LEN = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ifd_pkg::ADDR_W-1:0]      paddr,
    input  logic [ifd_pkg::DATA_W-1:0]      pwdata,
    output logic [ifd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_x,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_y,
    output logic signed [ifd_pkg::OUT_W-1:0] m_gyro_z,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_x,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_y,
    output logic signed [ifd_pkg::OUT_W-1:0] m_accel_z
);
    import ifd_pkg::*;

    logic [SCALE_W-1:0] gyro_scale_reg;
    logic [SCALE_W-1:0] accel_scale_reg;
    logic [TICK_W-1:0]  timeout_reg;
    logic               cfg_write;
    logic [1:0]         reg_index;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    job_t push_job;
    job_t pop_job;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_scale_reg  <= GYRO_SCALE_RST;
            accel_scale_reg <= ACCEL_SCALE_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_GYRO:    gyro_scale_reg  <= pwdata[SCALE_W-1:0];
                REG_ACCEL:   accel_scale_reg <= pwdata[SCALE_W-1:0];
                REG_TIMEOUT: timeout_reg     <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_GYRO:    prdata = DATA_W'(gyro_scale_reg);
            REG_ACCEL:   prdata = DATA_W'(accel_scale_reg);
            REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            default:     prdata = '0;
        endcase
    end

    ifd_front #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_rx_byte     (s_rx_byte),
        .timeout_ticks (timeout_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    ifd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_data  (push_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (pop_job)
    );

    ifd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .gyro_scale  (gyro_scale_reg),
        .accel_scale (accel_scale_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_gyro_x    (m_gyro_x),
        .m_gyro_y    (m_gyro_y),
        .m_gyro_z    (m_gyro_z),
        .m_accel_x   (m_accel_x),
        .m_accel_y   (m_accel_y),
        .m_accel_z   (m_accel_z)
    );

endmodule

@@ tb/sv/imu_frame_decoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the IMU frame decoder: serial words in, frame reports out.
// Depends on ifd_pkg and imu_frame_decoder; predicts every report and checks it field by field.
module imu_frame_decoder_tb;
    import ifd_pkg::*;

    localparam int FRAME_LEN = 25;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic [9:0][15:0] EDGE_WORDS = {16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF,
        16'h8000, 16'hB000, 16'hB001, 16'hBFFF, 16'hC000, 16'hFFFF};
    localparam logic [2:0][15:0] ZERO_WORDS = {16'h0000, 16'h4000, 16'h8000};

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } uart_word_t;

    typedef struct packed {
        status_t                        status;
        logic [NUM_AXES-1:0][OUT_W-1:0] vals;
    } report_t;

    typedef logic [NUM_AXES-1:0][15:0] words_t;

    typedef enum int {
        CK_GOOD,
        CK_BAD_FIRST,
        CK_BAD_SECOND
    } cksum_fault_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = CMD_BYTE;
    logic [7:0] s_rx_byte = 8'h00;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic signed [OUT_W-1:0] m_gyro_x, m_gyro_y, m_gyro_z;
    logic signed [OUT_W-1:0] m_accel_x, m_accel_y, m_accel_z;

    uart_word_t uart_q[$];
    report_t report_q[$];
    uart_word_t sent_word;
    report_t seen_rep;
    report_t want_rep;
    int fault_count = 0;
    int idle_pct = 26;
    int stall_cycles = 0;
    int gen_items = 0;
    int gen_results = 0;

    // Shadow copy of the decoder's registers and state.
    logic [SCALE_W-1:0] cfg_gyro = GYRO_SCALE_RST;
    logic [SCALE_W-1:0] cfg_accel = ACCEL_SCALE_RST;
    logic [TICK_W-1:0] cfg_tmo = TIMEOUT_RST;
    hunt_t hunt = HUNT_EE1;
    int pay_cnt = 0;
    logic [7:0] pay_store [STORE_DEPTH];
    logic [7:0] sum_first = 8'h00;
    logic [7:0] sum_second = 8'h00;
    int unsigned idle_cnt = 0;
    logic [NUM_AXES-1:0][OUT_W-1:0] last_vals = '0;

    imu_frame_decoder #(
        .PAYLOAD_LEN(FRAME_LEN)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_gyro_x(m_gyro_x),
        .m_gyro_y(m_gyro_y),
        .m_gyro_z(m_gyro_z),
        .m_accel_x(m_accel_x),
        .m_accel_y(m_accel_y),
        .m_accel_z(m_accel_z)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void post_report(input status_t st);
        report_t rep;
        rep.status = st;
        rep.vals = last_vals;
        report_q.push_back(rep);
    endfunction

    function automatic void close_frame();
        logic [15:0] raw;
        logic signed [15:0] val;
        longint prod;
        logic [NUM_AXES-1:0][OUT_W-1:0] fresh;
        bit nonzero;
        if (sum_first != SUM_OK || sum_second != SUM_OK) begin
            post_report(ST_CKSUM);
            return;
        end
        nonzero = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            raw = {pay_store[2 * k], pay_store[2 * k + 1]};
            if (raw > WORD_LIMIT) begin
                val = raw | WORD_NEG_SET;
            end else begin
                val = raw & WORD_POS_MASK;
            end
            if (val != 0) begin
                nonzero = 1'b1;
            end
            prod = longint'(val) * longint'(k < 3 ? cfg_gyro : cfg_accel);
            fresh[k] = prod[OUT_W-1:0];
        end
        if (!nonzero) begin
            post_report(ST_ZERO);
            return;
        end
        last_vals = fresh;
        post_report(ST_OK);
    endfunction

    function automatic void track_decoder(input logic cmd, input logic [7:0] b);
        if (cmd == CMD_TICK) begin
            if (idle_cnt >= cfg_tmo) begin
                idle_cnt = 0;
                hunt = HUNT_EE1;
                pay_cnt = 0;
                post_report(ST_TIMEOUT);
            end else begin
                idle_cnt++;
            end
            return;
        end
        idle_cnt = 0;
        case (hunt)
            HUNT_EE1: begin
                if (b == PRE_A) hunt = HUNT_EE2;
            end
            HUNT_EE2: begin
                hunt = (b == PRE_A) ? HUNT_50 : HUNT_EE1;
            end
            HUNT_50: begin
                if (b == PRE_B) begin
                    hunt = COLLECT;
                    pay_cnt = 0;
                    sum_first = 8'h00;
                    sum_second = 8'h00;
                end else begin
                    hunt = HUNT_EE1;
                end
            end
            default: begin
                if (pay_cnt < STORE_DEPTH) pay_store[pay_cnt] = b;
                if (pay_cnt < FIRST_END) begin
                    sum_first = sum_first + b;
                end else if (pay_cnt < SECOND_END) begin
                    sum_second = sum_second + b;
                end
                pay_cnt++;
                if (pay_cnt >= FRAME_LEN) begin
                    pay_cnt = 0;
                    hunt = HUNT_EE1;
                    close_frame();
                end
            end
        endcase
    endfunction

    // Sender: a new word is offered only once the previous one has gone.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_decoder(s_command, s_rx_byte);
            end
            if (!s_valid || s_ready) begin
                if (uart_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    sent_word = uart_q.pop_front();
                    s_command <= sent_word.cmd;
                    s_rx_byte <= sent_word.data;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_rep.status = status_t'(m_status);
                seen_rep.vals = {m_accel_z, m_accel_y, m_accel_x, m_gyro_z, m_gyro_y, m_gyro_x};
                if (report_q.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected report, status %0d", $time, m_status);
                end else begin
                    want_rep = report_q.pop_front();
                    if (seen_rep.status !== want_rep.status) begin
                        fault_count++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 want_rep.status, seen_rep.status);
                    end
                    for (int k = 0; k < NUM_AXES; k++) begin
                        if (seen_rep.vals[k] !== want_rep.vals[k]) begin
                            fault_count++;
                            $display("%0t: axis %0d expected %h got %h", $time, k,
                                     want_rep.vals[k], seen_rep.vals[k]);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GYRO: cfg_gyro = value[SCALE_W-1:0];
            REG_ACCEL: cfg_accel = value[SCALE_W-1:0];
            REG_TIMEOUT: cfg_tmo = value[TICK_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic write_all(input logic [23:0] gyro, input logic [23:0] accel,
                             input logic [15:0] tmo);
        reg_write(REG_GYRO, gyro);
        reg_write(REG_ACCEL, accel);
        reg_write(REG_TIMEOUT, tmo);
    endtask

    // The result for the final word can still be in the pipeline when the queue empties.
    task automatic wait_quiet();
        while (uart_q.size() != 0 || s_valid || report_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic add_word(input logic cmd, input logic [7:0] data);
        uart_word_t w;
        w.cmd = cmd;
        w.data = data;
        uart_q.push_back(w);
        gen_items++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_word(CMD_BYTE, b);
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_word(CMD_TICK, 8'($urandom));
    endtask

    // Short idle gaps inside a frame, never long enough to time out.
    task automatic add_gap(input bit gaps);
        int most;
        most = (int'(cfg_tmo) < 4) ? int'(cfg_tmo) : 4;
        if (gaps && most > 0 && $urandom_range(9) == 0) add_ticks($urandom_range(1, most));
    endtask

    function automatic words_t random_words(input bit edges);
        words_t w;
        for (int k = 0; k < NUM_AXES; k++) begin
            w[k] = edges ? EDGE_WORDS[$urandom_range(9)] : 16'($urandom);
        end
        return w;
    endfunction

    function automatic words_t zero_words();
        words_t w;
        for (int k = 0; k < NUM_AXES; k++) w[k] = ZERO_WORDS[$urandom_range(2)];
        return w;
    endfunction

    task automatic add_frame(input words_t w, input cksum_fault_t fault, input bit gaps);
        logic [7:0] body [FRAME_LEN];
        logic [7:0] acc;
        for (int k = 0; k < NUM_AXES; k++) begin
            body[2 * k] = w[k][15:8];
            body[2 * k + 1] = w[k][7:0];
        end
        acc = 8'h00;
        for (int i = 0; i < 12; i++) acc = acc + body[i];
        body[12] = SUM_OK - acc;
        acc = 8'h00;
        for (int i = FIRST_END; i < SECOND_END - 1; i++) begin
            body[i] = 8'($urandom);
            acc = acc + body[i];
        end
        body[SECOND_END - 1] = SUM_OK - acc;
        for (int i = SECOND_END; i < FRAME_LEN; i++) body[i] = 8'($urandom);
        if (fault == CK_BAD_FIRST) body[12] = body[12] + 8'($urandom_range(1, 255));
        if (fault == CK_BAD_SECOND) begin
            body[SECOND_END - 1] = body[SECOND_END - 1] + 8'($urandom_range(1, 255));
        end
        add_byte(PRE_A);
        add_gap(gaps);
        add_byte(PRE_A);
        add_gap(gaps);
        add_byte(PRE_B);
        for (int i = 0; i < FRAME_LEN; i++) begin
            add_gap(gaps);
            add_byte(body[i]);
        end
        gen_results++;
    endtask

    // A trailing zero byte leaves the hunt at its start unless the noise completed a preamble.
    task automatic add_noise(input int n);
        repeat (n) add_byte(8'($urandom));
        add_byte(8'h00);
    endtask

    task automatic add_broken_preamble();
        case ($urandom_range(3))
            0: begin
                add_byte(PRE_A);
                add_byte(PRE_B);
            end
            1: begin
                add_byte(PRE_A);
                add_byte(PRE_A);
                add_byte(PRE_A);
                add_byte(PRE_B);
            end
            2: begin
                add_byte(PRE_A);
                add_byte(PRE_A);
                add_byte(PRE_B ^ 8'($urandom_range(1, 255)));
            end
            default: begin
                add_byte(PRE_A ^ 8'($urandom_range(1, 255)));
                add_byte(PRE_A);
                add_byte(PRE_B);
            end
        endcase
        add_byte(8'h00);
    endtask

    task automatic add_timeout();
        if ($urandom_range(1) == 1) begin
            add_byte(PRE_A);
            add_byte(PRE_A);
            add_byte(PRE_B);
            repeat ($urandom_range(0, FRAME_LEN - 1)) add_byte(8'($urandom));
        end
        add_ticks(int'(cfg_tmo) + 1);
        gen_results++;
    endtask

    task automatic random_phase(input int want_items, input int want_reports);
        int r;
        int n;
        int item_mark;
        int report_mark;
        item_mark = gen_items;
        report_mark = gen_results;
        while (gen_items - item_mark < want_items || gen_results - report_mark < want_reports) begin
            r = $urandom_range(99);
            if (r < 40) begin
                add_frame(random_words($urandom_range(3) == 0), CK_GOOD, 1'b1);
            end else if (r < 45) begin
                add_frame(zero_words(), CK_GOOD, 1'b1);
            end else if (r < 52) begin
                add_frame(random_words(1'b0),
                          ($urandom_range(1) == 1) ? CK_BAD_FIRST : CK_BAD_SECOND, 1'b1);
            end else if (r < 60) begin
                add_noise($urandom_range(1, 12));
            end else if (r < 67) begin
                add_broken_preamble();
            end else if (r < 77 && cfg_tmo <= 64) begin
                add_timeout();
            end else if (r < 88) begin
                if (cfg_tmo == 0) begin
                    n = $urandom_range(1, 3);
                    gen_results += n;
                end else begin
                    n = $urandom_range(1, (cfg_tmo < 20) ? int'(cfg_tmo) : 20);
                end
                add_ticks(n);
                add_byte(8'h00);
            end else if (r < 91) begin
                wait_quiet();
            end else begin
                add_frame(random_words(1'b1), CK_GOOD, 1'b0);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: no resync on a third preamble byte, edge words, every status but timeout.
        add_byte(PRE_A);
        add_byte(PRE_A);
        add_byte(PRE_A);
        add_byte(PRE_B);
        add_byte(8'h00);
        add_frame({16'h7FFF, 16'hC000, 16'h3FFF, 16'hFFFF, 16'hB001, 16'hB000}, CK_GOOD, 1'b0);
        add_frame({16'h0000, 16'h0000, 16'h8000, 16'h4000, 16'h0000, 16'h8000}, CK_GOOD, 1'b0);
        add_frame(random_words(1'b0), CK_BAD_FIRST, 1'b0);
        add_frame(random_words(1'b0), CK_BAD_SECOND, 1'b0);
        add_ticks(3);
        add_byte(8'h00);
        wait_quiet();

        // A zero timeout fires on every idle tick, also in the middle of a payload.
        write_all(24'hFFFFFF, 24'hFFFFFF, 16'd0);
        add_ticks(2);
        add_frame({16'h4001, 16'hB001, 16'h0001, 16'h3FFF, 16'hFFFF, 16'hC000}, CK_GOOD, 1'b0);
        add_byte(PRE_A);
        add_byte(PRE_A);
        add_byte(PRE_B);
        add_noise(2);
        add_ticks(1);
        wait_quiet();

        write_all(24'($urandom), 24'($urandom), 16'($urandom_range(1, 40)));
        random_phase(150, 4);
        wait_quiet();

        write_all(24'h000000, 24'hFFFFFF, 16'd0);
        random_phase(150, 4);
        wait_quiet();

        // A long stretch without idling, ending on a timeout.
        idle_pct = 0;
        write_all(24'hFFFFFF, 24'h000000, 16'd40);
        random_phase(150, 4);
        add_ticks(int'(cfg_tmo) + 1);
        wait_quiet();
        idle_pct = 26;

        write_all(24'($urandom), 24'($urandom), 16'($urandom_range(1, 12)));
        random_phase(150, 4);
        wait_quiet();

        if (fault_count == 0 && report_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ifd_pkg.sv
sv/ifd_front.sv
sv/ifd_queue.sv
sv/ifd_back.sv
sv/imu_frame_decoder.sv
tb/sv/imu_frame_decoder_tb.sv
